@@ rtl/core/fixed_point_alu_q8_unit_defines.svh @@
// ----------------------------------------------------------------------------
// fixed-point alu assertion macros
// shared property wrappers on clk_i, with and without the reset qualifier
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_Q8_UNIT_DEFINES_SVH
`define FIXED_POINT_ALU_Q8_UNIT_DEFINES_SVH

// property checked only while out of reset
`define FPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property checked at every edge, reset included
`define FPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/core/fpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpa_pkg
// shared types and constants of the fixed-point alu
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fpa_pkg;

  localparam int unsigned FractionBitsDef = 8;
  localparam int unsigned DataW           = 32;
  localparam int unsigned QueueDepth      = 2;
  localparam int unsigned QPtrW           = 1;

  typedef enum logic [3:0] {
    ACT_ADD     = 4'd0,
    ACT_SUB     = 4'd1,
    ACT_MUL     = 4'd2,
    ACT_DIV     = 4'd3,
    ACT_GT      = 4'd4,
    ACT_LT      = 4'd5,
    ACT_GE      = 4'd6,
    ACT_LE      = 4'd7,
    ACT_NE      = 4'd8,
    ACT_EQ      = 4'd9,
    ACT_MIN     = 4'd10,
    ACT_MAX     = 4'd11,
    ACT_INC     = 4'd12,
    ACT_DEC     = 4'd13,
    ACT_TOINT   = 4'd14,
    ACT_FROMINT = 4'd15
  } action_e;

  // which part of the back end finishes the item
  typedef enum logic [1:0] {
    KIND_SIMPLE = 2'd0,
    KIND_MUL    = 2'd1,
    KIND_DIV    = 2'd2
  } kind_e;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_DIV_ZERO = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  localparam logic [DataW-1:0] RawMax = 32'h7fff_ffff;
  localparam logic [DataW-1:0] RawMin = 32'h8000_0000;

  typedef struct packed {
    action_e                  action;
    logic signed [DataW-1:0]  a;
    logic signed [DataW-1:0]  b;
  } item_t;

  typedef struct packed {
    kind_e kind;
    item_t item;
  } cls_item_t;

  typedef struct packed {
    logic      valid;
    cls_item_t data;
  } front_out_t;

endpackage

`default_nettype wire

@@ rtl/core/fpa_front.sv @@
// ----------------------------------------------------------------------------
// fpa_front
// accepts items, tags them by execution kind and queues them for the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpa_front import fpa_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [3:0]           s_axis_tuser_i,   // action
  input  wire logic [2*DataW-1:0]   s_axis_tdata_i,   // operand_a, operand_b
  input  wire logic                 pop_i,
  output front_out_t                head_o
);

  cls_item_t        mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   cnt_q;
  logic             push, pop;
  cls_item_t        cls;

  // classify the incoming item
  always_comb begin
    cls.item.action = action_e'(s_axis_tuser_i);
    cls.item.a      = s_axis_tdata_i[DataW-1:0];
    cls.item.b      = s_axis_tdata_i[2*DataW-1:DataW];
    case (cls.item.action)
      ACT_MUL: cls.kind = KIND_MUL;
      ACT_DIV: cls.kind = KIND_DIV;
      default: cls.kind = KIND_SIMPLE;
    endcase
  end

  assign s_axis_tready_o = (cnt_q != (QPtrW+1)'(QueueDepth));
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign pop             = pop_i && (cnt_q != '0);

  assign head_o.valid = (cnt_q != '0);
  assign head_o.data  = mem_q[rd_ptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_q + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/fpa_div.sv @@
// ----------------------------------------------------------------------------
// fpa_div
// pipelined restoring divider, one quotient bit per stage, with side tag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpa_div #(
  parameter int unsigned DivW = 41,
  parameter int unsigned DvsW = 32,
  parameter int unsigned TagW = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic [DivW-1:0] dividend_i,
  input  wire logic [DvsW-1:0] divisor_i,
  input  wire logic [TagW-1:0] tag_i,
  output logic                 valid_o,
  output logic [DivW-1:0]      quot_o,
  output logic [TagW-1:0]      tag_o
);

  logic            vld_q [DivW];
  logic [DivW-1:0] sh_q  [DivW];
  logic [DvsW-1:0] rem_q [DivW];
  logic [DvsW-1:0] dvs_q [DivW];
  logic [TagW-1:0] tag_q [DivW];

  for (genvar k = 0; k < DivW; k++) begin : g_stage
    logic            vld_in;
    logic [DivW-1:0] sh_in;
    logic [DvsW-1:0] rem_in, dvs_in, rem_n;
    logic [TagW-1:0] tag_in;
    logic [DvsW:0]   x;
    logic            ge;

    if (k == 0) begin : g_first
      assign vld_in = valid_i;
      assign sh_in  = dividend_i;
      assign rem_in = '0;
      assign dvs_in = divisor_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign vld_in = vld_q[k-1];
      assign sh_in  = sh_q[k-1];
      assign rem_in = rem_q[k-1];
      assign dvs_in = dvs_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    // trial subtract of the divisor from the shifted remainder
    assign x     = {rem_in, sh_in[DivW-1]};
    assign ge    = (x >= {1'b0, dvs_in});
    assign rem_n = ge ? DvsW'(x - {1'b0, dvs_in}) : x[DvsW-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sh_q[k]  <= {sh_in[DivW-2:0], ge};
        rem_q[k] <= rem_n;
        dvs_q[k] <= dvs_in;
        tag_q[k] <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[DivW-1];
  assign quot_o  = sh_q[DivW-1];
  assign tag_o   = tag_q[DivW-1];

endmodule

`default_nettype wire

@@ rtl/core/fpa_back.sv @@
// ----------------------------------------------------------------------------
// fpa_back
// execution pipeline: simple ops, multiply, divide and the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpa_back import fpa_pkg::*; #(
  parameter int unsigned FractionBits = FractionBitsDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  front_out_t         head_i,
  output logic               pop_o,
  output logic               m_axis_tvalid_o,
  input  wire logic          m_axis_tready_i,
  output logic [39:0]        m_axis_tdata_o   // result, compare_true, status, zero pad
);

  localparam int unsigned DivW = DataW + FractionBits + 1;

  typedef struct packed {
    kind_e            kind;
    logic [DataW-1:0] res;
    logic             cmp;
    logic [1:0]       st;
    logic             neg;
  } tag_t;

  localparam int unsigned TagW = $bits(tag_t);

  logic en;
  logic m_valid_q;
  logic [39:0] m_data_q;

  // first stage
  logic signed [DataW-1:0]   op_a, op_b;
  logic signed [DataW:0]     sum;
  logic                      sum_ovf;
  logic signed [2*DataW-1:0] wide;
  logic                      wide_ovf;
  logic [DataW-1:0]          s_res;
  logic                      s_cmp;
  logic [1:0]                s_st;
  kind_e                     s_kind;

  logic                      p1_valid_q;
  kind_e                     p1_kind_q;
  logic [DataW-1:0]          p1_res_q, p1_absa_q, p1_absb_q;
  logic                      p1_cmp_q, p1_neg_q;
  logic [1:0]                p1_st_q;
  logic signed [2*DataW-1:0] p1_prod_q;

  // second stage
  logic [2*DataW-1:0] mag, mag_r;
  logic               mul_neg, mul_ovf;
  logic [DataW-1:0]   mul_res;
  logic               p2_valid_q;
  tag_t               p2_tag_q;
  logic [DataW-1:0]   p2_absa_q, p2_absb_q;

  // divider and final stage
  logic               dv_valid;
  logic [DivW-1:0]    dv_quot;
  logic [TagW-1:0]    dv_tag_raw;
  tag_t               dv_tag;
  logic [DivW:0]      q_ext;
  logic [DivW-1:0]    q;
  logic               q_ovf;
  logic [DataW-1:0]   f_res;
  logic [1:0]         f_st;

  assign en    = !m_valid_q || m_axis_tready_i;
  assign pop_o = en && head_i.valid;

  assign op_a = head_i.data.item.a;
  assign op_b = head_i.data.item.b;

  // add, subtract, increment and decrement share one 33-bit adder
  always_comb begin
    case (head_i.data.item.action)
      ACT_SUB: sum = {op_a[DataW-1], op_a} - {op_b[DataW-1], op_b};
      ACT_INC: sum = {op_a[DataW-1], op_a} + (DataW+1)'(1);
      ACT_DEC: sum = {op_a[DataW-1], op_a} - (DataW+1)'(1);
      default: sum = {op_a[DataW-1], op_a} + {op_b[DataW-1], op_b};
    endcase
  end
  assign sum_ovf  = sum[DataW] ^ sum[DataW-1];

  // integer to fixed point, saturate when the shifted-out bits disagree
  assign wide     = (2*DataW)'(op_a) <<< FractionBits;
  assign wide_ovf = !((&wide[2*DataW-1:DataW-1]) || !(|wide[2*DataW-1:DataW-1]));

  // operations computed in full in the first stage
  always_comb begin
    s_res  = '0;
    s_cmp  = 1'b0;
    s_st   = STATUS_OK;
    s_kind = head_i.data.kind;
    case (head_i.data.item.action)
      ACT_ADD, ACT_SUB, ACT_INC, ACT_DEC: begin
        s_res = sum_ovf ? (sum[DataW] ? RawMin : RawMax) : sum[DataW-1:0];
        s_st  = sum_ovf ? STATUS_OVERFLOW : STATUS_OK;
      end
      ACT_GT:  s_cmp = (op_a >  op_b);
      ACT_LT:  s_cmp = (op_a <  op_b);
      ACT_GE:  s_cmp = (op_a >= op_b);
      ACT_LE:  s_cmp = (op_a <= op_b);
      ACT_NE:  s_cmp = (op_a != op_b);
      ACT_EQ:  s_cmp = (op_a == op_b);
      ACT_MIN: s_res = (op_a < op_b) ? op_a : op_b;
      ACT_MAX: s_res = (op_a > op_b) ? op_a : op_b;
      ACT_TOINT: s_res = op_a >>> FractionBits;
      ACT_FROMINT: begin
        s_res = wide_ovf ? (op_a[DataW-1] ? RawMin : RawMax) : wide[DataW-1:0];
        s_st  = wide_ovf ? STATUS_OVERFLOW : STATUS_OK;
      end
      ACT_DIV: begin
        // division by zero is settled here and skips the divider result
        if (op_b == '0) begin
          s_kind = KIND_SIMPLE;
          s_res  = op_a[DataW-1] ? RawMin : RawMax;
          s_st   = STATUS_DIV_ZERO;
        end
      end
      default: s_res = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else if (en) begin
      p1_valid_q <= head_i.valid;
      p2_valid_q <= p1_valid_q;
      m_valid_q  <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_kind_q <= s_kind;
      p1_res_q  <= s_res;
      p1_cmp_q  <= s_cmp;
      p1_st_q   <= s_st;
      p1_prod_q <= op_a * op_b;
      p1_neg_q  <= op_a[DataW-1] ^ op_b[DataW-1];
      p1_absa_q <= op_a[DataW-1] ? DataW'(-op_a) : op_a;
      p1_absb_q <= op_b[DataW-1] ? DataW'(-op_b) : op_b;
    end
  end

  // product rounding half away from zero, then saturation
  assign mul_neg = p1_prod_q[2*DataW-1];
  assign mag     = mul_neg ? (2*DataW)'(-p1_prod_q) : p1_prod_q;
  assign mag_r   = (mag + ((2*DataW)'(1) << (FractionBits - 1))) >> FractionBits;
  assign mul_ovf = mul_neg ? (mag_r > (2*DataW)'(RawMin)) : (mag_r > (2*DataW)'(RawMax));
  always_comb begin
    if (mul_ovf) begin
      mul_res = mul_neg ? RawMin : RawMax;
    end else begin
      mul_res = mul_neg ? DataW'(-mag_r[DataW-1:0]) : mag_r[DataW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_tag_q.kind <= p1_kind_q;
      p2_tag_q.cmp  <= p1_cmp_q;
      p2_tag_q.neg  <= p1_neg_q;
      p2_tag_q.res  <= (p1_kind_q == KIND_MUL) ? mul_res : p1_res_q;
      p2_tag_q.st   <= (p1_kind_q == KIND_MUL && mul_ovf) ? STATUS_OVERFLOW : p1_st_q;
      p2_absa_q     <= p1_absa_q;
      p2_absb_q     <= p1_absb_q;
    end
  end

  // quotient of twice the scaled dividend, one bit per stage
  fpa_div #(
    .DivW (DivW),
    .DvsW (DataW),
    .TagW (TagW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (p2_valid_q),
    .dividend_i ({p2_absa_q, (FractionBits + 1)'(0)}),
    .divisor_i  (p2_absb_q),
    .tag_i      (TagW'(p2_tag_q)),
    .valid_o    (dv_valid),
    .quot_o     (dv_quot),
    .tag_o      (dv_tag_raw)
  );

  assign dv_tag = tag_t'(dv_tag_raw);

  // halve with round up gives the half-away rounding of the magnitude
  assign q_ext = ({1'b0, dv_quot} + (DivW+1)'(1)) >> 1;
  assign q     = q_ext[DivW-1:0];
  assign q_ovf = dv_tag.neg ? (q > DivW'(RawMin)) : (q > DivW'(RawMax));

  always_comb begin
    f_res = dv_tag.res;
    f_st  = dv_tag.st;
    if (dv_tag.kind == KIND_DIV) begin
      if (q_ovf) begin
        f_res = dv_tag.neg ? RawMin : RawMax;
        f_st  = STATUS_OVERFLOW;
      end else begin
        f_res = dv_tag.neg ? DataW'(-q[DataW-1:0]) : q[DataW-1:0];
        f_st  = STATUS_OK;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_data_q <= {5'd0, f_st, dv_tag.cmp, f_res};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

`default_nettype wire

@@ rtl/core/fixed_point_alu_q8_unit.sv @@
// Throughput: one item per cycle while the output is not stalled; the divider is fully
// pipelined, one quotient bit per stage, and has FRACTION_BITS + 33 stages.
// A two-entry input queue decouples acceptance from the execution pipeline.
// Reset (rst_ni low, asynchronous) empties the queue and drops all items in flight.
// ----------------------------------------------------------------------------
// fixed_point_alu_q8_unit
// signed 32-bit fixed-point alu with saturating arithmetic, streaming ports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fixed_point_alu_q8_unit import fpa_pkg::*; #(
  parameter int unsigned FractionBits = FractionBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [3:0]  s_axis_tuser_i,   // action
  input  wire logic [63:0] s_axis_tdata_i,   // operand_a, operand_b
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o    // result, compare_true, status, zero pad
);

  front_out_t head;
  logic       pop;

  fpa_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .pop_i           (pop),
    .head_o          (head)
  );

  fpa_back #(
    .FractionBits (FractionBits)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/fpa_checker.sv @@
// ----------------------------------------------------------------------------
// fpa_checker
// port-level checks of the fixed-point alu, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_point_alu_q8_unit_defines.svh"

module fpa_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic [3:0]  s_axis_tuser_i,
  input wire logic [63:0] s_axis_tdata_i,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [39:0] m_axis_tdata_o
);

  // a stalled result holds
  `FPA_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled result changed")
  // nothing is offered while in reset
  `FPA_ASSERT_ALWAYS(a_rst_empty, !rst_ni |-> !m_axis_tvalid_o, "result valid during reset")
  // a true compare carries a zero result and ok status
  `FPA_ASSERT(a_cmp_zero, m_axis_tvalid_o && m_axis_tdata_o[32] |-> m_axis_tdata_o[31:0] == 32'd0 && m_axis_tdata_o[34:33] == 2'd0, "compare with nonzero result")
  // status code three never appears
  `FPA_ASSERT(a_status_code, m_axis_tvalid_o |-> m_axis_tdata_o[34:33] != 2'd3, "bad status code")
  // saturated results sit at a range limit
  `FPA_ASSERT(a_sat_limit, m_axis_tvalid_o && m_axis_tdata_o[34:33] != 2'd0 |-> m_axis_tdata_o[31:0] == 32'h7fff_ffff || m_axis_tdata_o[31:0] == 32'h8000_0000, "saturation off limit")

endmodule

bind fixed_point_alu_q8_unit fpa_checker u_fpa_checker (.*);

`default_nettype wire

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// stream-level check of the fixed-point alu: directed corner items, then
// random items under several idle and stall mixes, each result compared with
// a predicted value in a small scoreboard
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
  import fpa_pkg::*;

  localparam int FracBits = 8;
  localparam int Latency  = 44;

  // expected outcome of one alu item
  typedef struct packed {
    logic [31:0] result;
    logic        cmp;
    logic [1:0]  status;
  } alu_out_t;

  // scoreboard: predicts each accepted item and checks results in order
  class alu_scoreboard;
    alu_out_t pending_q[$];
    int       n_err;
    int       n_done;

    function automatic logic [31:0] clamp_wide(longint v, ref logic [1:0] st);
      if (v > 64'sd2147483647) begin
        st = STATUS_OVERFLOW;
        return RawMax;
      end
      if (v < -64'sd2147483648) begin
        st = STATUS_OVERFLOW;
        return RawMin;
      end
      return v[31:0];
    endfunction

    function automatic logic [31:0] signed_mag(bit neg, longint unsigned mag,
                                               ref logic [1:0] st);
      if (!neg && mag > 64'h7fff_ffff) begin
        st = STATUS_OVERFLOW;
        mag = 64'h7fff_ffff;
      end
      if (neg && mag > 64'h8000_0000) begin
        st = STATUS_OVERFLOW;
        mag = 64'h8000_0000;
      end
      return neg ? 32'(64'd0 - mag) : 32'(mag);
    endfunction

    function automatic alu_out_t compute(action_e act, logic [31:0] ra,
                                         logic [31:0] rb);
      longint          a;
      longint          b;
      longint          p;
      longint unsigned mag;
      longint unsigned num;
      longint unsigned den;
      alu_out_t        o;
      logic [1:0]      st;
      a  = longint'(signed'(ra));
      b  = longint'(signed'(rb));
      o  = '0;
      st = STATUS_OK;
      case (act)
        ACT_ADD: o.result = clamp_wide(a + b, st);
        ACT_SUB: o.result = clamp_wide(a - b, st);
        ACT_MUL: begin
          p   = a * b;
          mag = (p < 0) ? -p : p;
          mag = (mag + (64'd1 << (FracBits - 1))) >> FracBits;
          o.result = signed_mag(p < 0, mag, st);
        end
        ACT_DIV: begin
          if (b == 0) begin
            st = STATUS_DIV_ZERO;
            o.result = (a < 0) ? RawMin : RawMax;
          end else begin
            num = ((a < 0) ? -a : a) << FracBits;
            den = (b < 0) ? -b : b;
            o.result = signed_mag((a < 0) != (b < 0), (2 * num + den) / (2 * den), st);
          end
        end
        ACT_GT:      o.cmp = a > b;
        ACT_LT:      o.cmp = a < b;
        ACT_GE:      o.cmp = a >= b;
        ACT_LE:      o.cmp = a <= b;
        ACT_NE:      o.cmp = a != b;
        ACT_EQ:      o.cmp = a == b;
        ACT_MIN:     o.result = (a < b) ? ra : rb;
        ACT_MAX:     o.result = (a > b) ? ra : rb;
        ACT_INC:     o.result = clamp_wide(a + 1, st);
        ACT_DEC:     o.result = clamp_wide(a - 1, st);
        ACT_TOINT:   o.result = signed'(ra) >>> FracBits;
        default:     o.result = clamp_wide(a * (64'sd1 <<< FracBits), st);
      endcase
      o.status = st;
      return o;
    endfunction

    function void note_item(action_e act, logic [31:0] ra, logic [31:0] rb);
      pending_q.push_back(compute(act, ra, rb));
    endfunction

    function void check_result(logic [39:0] data);
      alu_out_t exp_o;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: %h", data);
        n_err++;
        return;
      end
      exp_o = pending_q.pop_front();
      n_done++;
      if (data[31:0] !== exp_o.result) begin
        $error("result: expected %h actual %h", exp_o.result, data[31:0]);
        n_err++;
      end
      if (data[32] !== exp_o.cmp) begin
        $error("compare_true: expected %b actual %b", exp_o.cmp, data[32]);
        n_err++;
      end
      if (data[34:33] !== exp_o.status) begin
        $error("status: expected %0d actual %0d", exp_o.status, data[34:33]);
        n_err++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [3:0]  s_axis_tuser_i;   // action
  logic [63:0] s_axis_tdata_i;   // operand_a, operand_b
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [39:0] m_axis_tdata_o;   // result, compare_true, status, zero pad

  alu_scoreboard sb;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_cycles;
  int  n_sent;

  fixed_point_alu_q8_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
      if (hold_cycles > 0) begin
        hold_cycles     <= hold_cycles - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // offer one item and wait until it is taken
  task automatic send_item(action_e act, logic [31:0] ra, logic [31:0] rb);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= act;
    s_axis_tdata_i  <= {rb, ra};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_item(act, ra, rb);
    n_sent++;
  endtask

  // operand biased toward corners and small values
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return RawMax - $urandom_range(2);
      1: return RawMin + $urandom_range(2);
      2: return $urandom_range(3) - 1;
      3: return 32'($signed($urandom_range(2000)) - 1000);
      4: return 32'($signed($urandom_range(20000)) - 10000) << 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(int count);
    action_e act;
    logic [31:0] ra;
    logic [31:0] rb;
    repeat (count) begin
      act = action_e'($urandom_range(15));
      ra  = pick_operand();
      rb  = ($urandom_range(3) == 0) ? ra : pick_operand();
      send_item(act, ra, rb);
    end
  endtask

  // stimulus
  initial begin
    action_e act;
    sb = new();
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_cycles     = 0;
    n_sent          = 0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tuser_i  = ACT_ADD;
    s_axis_tdata_i  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every operation at the extremes, then the named corner cases
    act = act.first();
    do begin
      send_item(act, RawMax, RawMin);
      act = act.next();
    end while (act != act.first());
    send_item(ACT_ADD, RawMax, 32'd1);
    send_item(ACT_SUB, RawMin, 32'd1);
    send_item(ACT_MUL, RawMax, RawMax);
    send_item(ACT_MUL, 32'h0000_0180, 32'hffff_ff80);
    send_item(ACT_DIV, 32'hffff_ff00, 32'd0);
    send_item(ACT_DIV, 32'd0, 32'd0);
    send_item(ACT_DIV, RawMin, 32'hffff_ffff);
    send_item(ACT_INC, RawMax, 32'd0);
    send_item(ACT_DEC, RawMin, 32'd0);
    send_item(ACT_FROMINT, 32'h0080_0000, 32'd0);
    send_item(ACT_MIN, 32'd5, 32'd5);
    send_item(ACT_TOINT, 32'hffff_ff01, 32'd0);

    // long receiver hold-off while items keep coming
    hold_cycles = 200;
    run_random(60);

    send_idle_pct = 0;  recv_stall_pct = 0;  run_random(340);
    send_idle_pct = 78; recv_stall_pct = 0;  run_random(330);
    send_idle_pct = 0;  recv_stall_pct = 78; run_random(330);
    send_idle_pct = 16; recv_stall_pct = 16; run_random(330);
    s_axis_tvalid_i <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    $display("covered %0d items over all sixteen operations, %0d results checked",
             n_sent, sb.n_done);
    $display("idle mixes: none, sender 78%%, receiver 78%%, both 16%%, plus a long stall");
    if (sb.n_err == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // timeout
  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
